// ===== rtl/binary_window_erosion_top_defines.svh =====
// Assertion macros shared by the checker of binary_window_erosion_top.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BINARY_WINDOW_EROSION_TOP_DEFINES_SVH
`define BINARY_WINDOW_EROSION_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bwe_checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define BWE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bwe_checker: next-cycle property failed");

`endif

// ===== rtl/bwe_pkg.sv =====
// Shared types and constants of the binary window erosion block.
// No dependencies; the interfaces and all modules but bwe_checker import this package.
`timescale 1ns / 1ps

package bwe_pkg;

  localparam int COORD_W    = 10;   // column and row of a pixel
  localparam int DIM_W      = 11;   // frame size registers
  localparam int PIX_W      = 8;
  localparam int RING_ROWS  = 4;    // rows kept in the line memory
  localparam int RING_W     = 2;
  localparam int WIN_SIZE   = 3;
  localparam int DIM_LIMIT  = 1024;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [PIX_W-1:0] WHITE = 8'd255;
  localparam logic [PIX_W-1:0] BLACK = 8'd0;

  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [RING_W-1:0]    ring_t;
  typedef logic [RING_ROWS-1:0] ring_word_t;
  typedef logic [WIN_SIZE-1:0]  column_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_kind_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Line memory access issued in the accept cycle.
  typedef struct packed {
    logic   wr_en;
    coord_t wr_col;
    ring_t  wr_ring;
    logic   wr_bit;
    coord_t rd_col_a;
    coord_t rd_col_b;
  } mem_req_t;

  // Control word that travels with a result into the window stage.
  typedef struct packed {
    logic   valid;
    logic   overrun;
    logic   done;
    coord_t col;
    coord_t row;
    ring_t  ring;
    logic   top_ok;
    logic   bot_ok;
    logic   right_ok;
    logic   row_start;
  } s1_ctl_t;

  typedef struct packed {
    pix_t   pixel_out;
    coord_t out_col;
    coord_t out_row;
    logic   frame_done;
    logic   overrun;
  } res_t;

endpackage

// ===== rtl/bwe_if.sv =====
// Valid/ready channel interfaces of the binary window erosion block.
// Depends on bwe_pkg for the field widths.
`timescale 1ns / 1ps

interface bwe_in_if import bwe_pkg::*; ();
  logic valid;
  logic ready;
  logic req_type;
  pix_t pixel_in;

  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

interface bwe_out_if import bwe_pkg::*; ();
  logic   valid;
  logic   ready;
  pix_t   pixel_out;
  coord_t out_col;
  coord_t out_row;
  logic   frame_done;
  logic   overrun;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output frame_done, output overrun, input ready);
  modport sink   (input valid, input pixel_out, input out_col, input out_row,
                  input frame_done, input overrun, output ready);
endinterface

// ===== rtl/bwe_ctrl.sv =====
// Position counters and emit decision of the erosion block.
// Issues the line memory accesses and the control word of the window stage; uses bwe_pkg.
`timescale 1ns / 1ps

module bwe_ctrl import bwe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 restart,
  input  dim_t                 width,
  input  dim_t                 height,
  input  logic                 in_valid,
  input  logic                 req_type,
  input  pix_t                 pixel_in,
  input  logic [FIFO_CW-1:0]   fifo_count,
  output logic                 in_ready,
  output mem_req_t             mem_req,
  output s1_ctl_t              s1
);

  coord_t  in_col_r, in_col_nxt;
  dim_t    in_row_r, in_row_nxt;
  coord_t  emit_col_r, emit_col_nxt;
  coord_t  emit_row_r, emit_row_nxt;
  dim_t    gap_r, gap_nxt;
  s1_ctl_t s1_r, s1_nxt;

  logic               acc, is_pix, all_in, ovr, wr, in_last, emit, e_last, done;
  dim_t               in_col_inc, emit_col_inc, emit_row_inc, gap_wr;
  logic [DIM_W:0]     thr;
  logic [FIFO_CW-1:0] occupancy;

  always_comb begin
    // Items in the window stage already own a queue slot.
    occupancy = fifo_count + FIFO_CW'(s1_r.valid);
    in_ready  = (occupancy < FIFO_CW'(FIFO_DEPTH));
    acc       = in_valid && in_ready;
    is_pix    = (req_type == REQ_PIXEL);
    all_in    = (in_row_r >= height);
    ovr       = acc && is_pix && all_in;
    wr        = acc && is_pix && !all_in;

    in_col_inc = {1'b0, in_col_r} + DIM_W'(1);
    in_last    = (in_col_inc >= width);
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (wr) begin
      if (in_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + DIM_W'(1);
      end else begin
        in_col_nxt = in_col_inc[COORD_W-1:0];
      end
    end

    // gap counts pixels received but not yet emitted; an output is due once the pixel
    // below and right of it has arrived, or once the whole frame is in.
    gap_wr = gap_r + DIM_W'(wr);
    thr    = {1'b0, width} + (DIM_W+1)'(1);
    emit   = acc && !ovr && ((in_row_nxt >= height) || ({1'b0, gap_wr} > thr));

    emit_col_inc = {1'b0, emit_col_r} + DIM_W'(1);
    emit_row_inc = {1'b0, emit_row_r} + DIM_W'(1);
    e_last       = (emit_col_inc >= width);
    done         = emit && e_last && (emit_row_inc >= height);

    emit_col_nxt = emit_col_r;
    emit_row_nxt = emit_row_r;
    if (emit) begin
      if (e_last) begin
        emit_col_nxt = '0;
        emit_row_nxt = emit_row_inc[COORD_W-1:0];
      end else begin
        emit_col_nxt = emit_col_inc[COORD_W-1:0];
      end
    end
    gap_nxt = gap_wr - DIM_W'(emit);

    mem_req.wr_en    = wr;
    mem_req.wr_col   = in_col_r;
    mem_req.wr_ring  = in_row_r[RING_W-1:0];
    mem_req.wr_bit   = (pixel_in == BLACK);
    mem_req.rd_col_a = e_last ? '0 : emit_col_inc[COORD_W-1:0];
    mem_req.rd_col_b = emit_col_r;

    s1_nxt.valid     = emit || ovr;
    s1_nxt.overrun   = ovr;
    s1_nxt.done      = done;
    s1_nxt.col       = emit_col_r;
    s1_nxt.row       = emit_row_r;
    s1_nxt.ring      = emit_row_r[RING_W-1:0];
    s1_nxt.top_ok    = (emit_row_r != '0);
    s1_nxt.bot_ok    = (emit_row_inc < height);
    s1_nxt.right_ok  = !e_last;
    s1_nxt.row_start = (emit_col_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      emit_col_r <= '0;
      emit_row_r <= '0;
      gap_r      <= '0;
      s1_r       <= '0;
    end else begin
      s1_r <= s1_nxt;
      if (restart || done) begin
        in_col_r   <= '0;
        in_row_r   <= '0;
        emit_col_r <= '0;
        emit_row_r <= '0;
        gap_r      <= '0;
      end else begin
        in_col_r   <= in_col_nxt;
        in_row_r   <= in_row_nxt;
        emit_col_r <= emit_col_nxt;
        emit_row_r <= emit_row_nxt;
        gap_r      <= gap_nxt;
      end
    end
  end

  assign s1 = s1_r;

endmodule

// ===== rtl/bwe_line_mem.sv =====
// Line memory of the erosion block: one black flag per pixel for four rows.
// Word per column, one write and two registered reads a cycle; uses bwe_pkg.
`timescale 1ns / 1ps

module bwe_line_mem import bwe_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic       clk,
  input  mem_req_t   req,
  output ring_word_t rd_a,
  output ring_word_t rd_b
);

  localparam int AW = $clog2(DEPTH);

  ring_word_t mem [DEPTH];
  ring_word_t rd_a_r, rd_b_r;
  logic       fwd_a_r, fwd_b_r, fwd_bit_r;
  ring_t      fwd_ring_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_col[AW-1:0]][req.wr_ring] <= req.wr_bit;
    end
    rd_a_r <= mem[req.rd_col_a[AW-1:0]];
    rd_b_r <= mem[req.rd_col_b[AW-1:0]];
  end

  // A read of the column being written this cycle takes the new flag.
  always_ff @(posedge clk) begin
    fwd_a_r    <= req.wr_en && (req.wr_col[AW-1:0] == req.rd_col_a[AW-1:0]);
    fwd_b_r    <= req.wr_en && (req.wr_col[AW-1:0] == req.rd_col_b[AW-1:0]);
    fwd_ring_r <= req.wr_ring;
    fwd_bit_r  <= req.wr_bit;
  end

  always_comb begin
    rd_a = rd_a_r;
    rd_b = rd_b_r;
    if (fwd_a_r) begin
      rd_a[fwd_ring_r] = fwd_bit_r;
    end
    if (fwd_b_r) begin
      rd_b[fwd_ring_r] = fwd_bit_r;
    end
  end

endmodule

// ===== rtl/bwe_window.sv =====
// Window stage of the erosion block: holds the left and center columns and
// forms the result from them and the column just read; uses bwe_pkg.
`timescale 1ns / 1ps

module bwe_window import bwe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  s1_ctl_t    s1,
  input  ring_word_t col_a,
  input  ring_word_t col_b,
  output logic       push,
  output res_t       res
);

  column_t left_r, center_r;
  column_t lft, ctr, rgt;
  logic    black;

  // The emitted row and the rows above and below it, masked at the frame edges.
  function automatic column_t pick_column(ring_word_t word, ring_t ring,
                                          logic top_ok, logic bot_ok);
    column_t c;
    c[0] = word[ring - RING_W'(1)] & top_ok;
    c[1] = word[ring];
    c[2] = word[ring + RING_W'(1)] & bot_ok;
    return c;
  endfunction

  always_comb begin
    rgt   = pick_column(col_a, s1.ring, s1.top_ok, s1.bot_ok) & {WIN_SIZE{s1.right_ok}};
    ctr   = s1.row_start ? pick_column(col_b, s1.ring, s1.top_ok, s1.bot_ok) : center_r;
    lft   = s1.row_start ? '0 : left_r;
    black = |{lft, ctr, rgt};

    push = s1.valid;
    if (s1.overrun) begin
      res = '{pixel_out: BLACK, out_col: '0, out_row: '0, frame_done: 1'b0, overrun: 1'b1};
    end else begin
      res.pixel_out  = black ? BLACK : WHITE;
      res.out_col    = s1.col;
      res.out_row    = s1.row;
      res.frame_done = s1.done;
      res.overrun    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      center_r <= '0;
    end else if (s1.valid && !s1.overrun) begin
      left_r   <= ctr;
      center_r <= rgt;
    end
  end

endmodule

// ===== rtl/bwe_out_fifo.sv =====
// Four-entry result queue between the window stage and the output channel.
// Uses bwe_pkg for the result type.
`timescale 1ns / 1ps

module bwe_out_fifo import bwe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  res_t               push_data,
  input  logic               pop_ready,
  output logic               head_valid,
  output res_t               head,
  output logic [FIFO_CW-1:0] count
);

  res_t                entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wptr_r, rptr_r;
  logic [FIFO_CW-1:0]  count_r;
  logic                pop;

  assign head_valid = (count_r != '0);
  assign head       = entries[rptr_r];
  assign count      = count_r;
  assign pop        = head_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

endmodule

// ===== rtl/binary_window_erosion_top.sv =====
// Binary 3x3 erosion of a raster-order gray image; top level with the APB
// size registers. Uses bwe_pkg, bwe_if, bwe_ctrl, bwe_line_mem, bwe_window, bwe_out_fifo.
// Input requests: a pixel (req_type 0, value 0 is black) or a flush tick (req_type 1).
// Each output is 0 if any in-frame pixel of its 3x3 window is black, else 255, with
// its column, row, a frame_done flag on the last pixel of the frame, and an overrun
// flag on a pixel request that arrives after the last pixel and before frame_done.
// Throughput: one request per clock while in_ch.ready is high; each request costs two line
// memory reads, and each pixel request one write, in its accept cycle. A result passes the
// window stage register and then the result queue. Outputs lag the input by width+1 pixels;
// after the last pixel, one flush request per pending output drains the frame.
// Reset: counters clear, frame_width 640, frame_height 480. The line memory is not
// cleared: every flag a window reads was written earlier in the same frame.
// Writing a size register restarts the frame. When the receiver stalls, results
// wait in a four-entry queue and in_ch.ready falls once queue and window stage hold four.
`timescale 1ns / 1ps

module binary_window_erosion_top import bwe_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  bwe_in_if.sink              in_ch,
  bwe_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  localparam int COL_LIMIT = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;

  dim_t               width_r, height_r;
  dim_t               width_eff, height_eff;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic               fifo_in_ready;
  logic [FIFO_CW-1:0] fifo_count;
  mem_req_t           mem_req;
  s1_ctl_t            s1;
  ring_word_t         col_a, col_b;
  logic               push;
  res_t               res, head;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = {{(CFG_DW-DIM_W){1'b0}}, width_r};
      REG_FRAME_HEIGHT: prdata = {{(CFG_DW-DIM_W){1'b0}}, height_r};
      default:          prdata = '0;
    endcase
  end

  // Zero counts as one; a larger width saturates at the line memory depth, a larger height at DIM_LIMIT.
  always_comb begin
    if (width_r == '0) begin
      width_eff = DIM_W'(1);
    end else if (width_r > DIM_W'(COL_LIMIT)) begin
      width_eff = DIM_W'(COL_LIMIT);
    end else begin
      width_eff = width_r;
    end
    if (height_r == '0) begin
      height_eff = DIM_W'(1);
    end else if (height_r > DIM_W'(DIM_LIMIT)) begin
      height_eff = DIM_W'(DIM_LIMIT);
    end else begin
      height_eff = height_r;
    end
  end

  bwe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .width      (width_eff),
    .height     (height_eff),
    .in_valid   (in_ch.valid),
    .req_type   (in_ch.req_type),
    .pixel_in   (in_ch.pixel_in),
    .fifo_count (fifo_count),
    .in_ready   (fifo_in_ready),
    .mem_req    (mem_req),
    .s1         (s1)
  );

  assign in_ch.ready = fifo_in_ready;

  bwe_line_mem #(
    .DEPTH (COL_LIMIT)
  ) u_line_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (col_a),
    .rd_b (col_b)
  );

  bwe_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .col_a (col_a),
    .col_b (col_b),
    .push  (push),
    .res   (res)
  );

  bwe_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .pop_ready  (out_ch.ready),
    .head_valid (out_ch.valid),
    .head       (head),
    .count      (fifo_count)
  );

  assign out_ch.pixel_out  = head.pixel_out;
  assign out_ch.out_col    = head.out_col;
  assign out_ch.out_row    = head.out_row;
  assign out_ch.frame_done = head.frame_done;
  assign out_ch.overrun    = head.overrun;

endmodule

// ===== rtl/bwe_checker.sv =====
// Port-level checker of binary_window_erosion_top and its bind statement.
// Uses the assertion macros of binary_window_erosion_top_defines.svh.
`timescale 1ns / 1ps
`include "binary_window_erosion_top_defines.svh"

module bwe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pixel_out,
  input logic [9:0] out_col,
  input logic [9:0] out_row,
  input logic       frame_done,
  input logic       overrun
);

  // An eroded pixel is either fully black or fully white.
  `BWE_ASSERT_IMP(a_binary_pixel, out_valid && !overrun, pixel_out == 8'd0 || pixel_out == 8'd255)

  // A discarded pixel reports only the overrun flag.
  `BWE_ASSERT_IMP(a_overrun_clean, out_valid && overrun, pixel_out == 8'd0 && out_col == 10'd0 && out_row == 10'd0 && !frame_done)

  // A stalled result stays on the port unchanged.
  `BWE_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(out_col) && $stable(out_row) && $stable(frame_done) && $stable(overrun))

endmodule

bind binary_window_erosion_top bwe_checker u_bwe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_out  (out_ch.pixel_out),
  .out_col    (out_ch.out_col),
  .out_row    (out_ch.out_row),
  .frame_done (out_ch.frame_done),
  .overrun    (out_ch.overrun)
);
